// ===== sv/owb_pkg.sv =====
// Shared types and timing constants for the 1-Wire bus master.
`default_nettype none
package owb_pkg;

  // Slot and reset timing in one-microsecond ticks
  localparam logic [8:0] RESET_LOW_TICKS = 9'd480;
  localparam logic [8:0] RST_WAIT_TICKS  = 9'd70;
  localparam logic [8:0] RST_REC_TICKS   = 9'd410;
  localparam logic [8:0] WR0_LOW_TICKS   = 9'd60;
  localparam logic [8:0] WR0_HIGH_TICKS  = 9'd10;
  localparam logic [8:0] WR1_LOW_TICKS   = 9'd6;
  localparam logic [8:0] WR1_HIGH_TICKS  = 9'd64;
  localparam logic [8:0] RD_LOW_TICKS    = 9'd6;
  localparam logic [8:0] RD_WAIT_TICKS   = 9'd9;
  localparam logic [8:0] RD_REC_TICKS    = 9'd55;
  localparam logic [8:0] ONE_TICK        = 9'd1;

  localparam logic [2:0] LAST_BIT = 3'd7;

  typedef enum logic [3:0] {
    PH_IDLE,
    PH_RST_LOW,
    PH_RST_WT,
    PH_RST_REC,
    PH_WR_LOW,
    PH_WR_HIGH,
    PH_RD_LOW,
    PH_RD_WT,
    PH_RD_REC
  } phase_t;

  typedef enum logic [1:0] {
    KIND_TICK,
    KIND_RESET,
    KIND_WRITE,
    KIND_READ
  } kind_t;

  // One input beat
  typedef struct packed {
    kind_t      kind;
    logic [7:0] tx_byte;
    logic       bus_level;
  } item_t;

  // One result beat, drive_low in the lowest bit
  typedef struct packed {
    logic       rejected;
    logic       presence_level;
    logic [7:0] rx_byte;
    logic       done_res;
    logic       busy_res;
    logic       drive_low;
  } result_t;

endpackage
`default_nettype wire

// ===== sv/owb_in_stage.sv =====
// Input register stage: holds one accepted beat until the engine takes it.
`default_nettype none
module owb_in_stage (
  input  wire            clk,
  input  wire            rst_n,
  input  wire            in_valid,
  output logic           in_ready,
  input  owb_pkg::item_t in_item,
  input  wire            take,
  output logic           item_valid,
  output owb_pkg::item_t item
);
  import owb_pkg::*;

  logic  valid_r, valid_nxt;
  item_t item_r, item_nxt;

  // Accept when empty or when the held beat leaves this cycle
  assign in_ready = !valid_r || take;

  always_comb begin
    valid_nxt = valid_r;
    item_nxt  = item_r;
    if (in_valid && in_ready) begin
      valid_nxt = 1'b1;
      item_nxt  = in_item;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    item_r <= item_nxt;
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule
`default_nettype wire

// ===== sv/owb_engine.sv =====
// Bus timing engine: phase, tick and bit counters updated once per beat.
`default_nettype none
module owb_engine (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              step,
  input  owb_pkg::item_t   item,
  output owb_pkg::result_t result
);
  import owb_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [8:0] tick_r, tick_nxt;
  logic [2:0] bit_r, bit_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic       presence_r, presence_nxt;
  logic [7:0] rx_r, rx_nxt;
  logic       done, rej, fin;
  logic [8:0] len;
  logic [9:0] tick_inc;

  // Length of the current phase
  always_comb begin
    case (phase_r)
      PH_RST_LOW: len = RESET_LOW_TICKS;
      PH_RST_WT:  len = RST_WAIT_TICKS;
      PH_RST_REC: len = RST_REC_TICKS;
      PH_WR_LOW:  len = shift_r[0] ? WR1_LOW_TICKS : WR0_LOW_TICKS;
      PH_WR_HIGH: len = shift_r[0] ? WR1_HIGH_TICKS : WR0_HIGH_TICKS;
      PH_RD_LOW:  len = RD_LOW_TICKS;
      PH_RD_WT:   len = RD_WAIT_TICKS;
      PH_RD_REC:  len = RD_REC_TICKS;
      default:    len = ONE_TICK;
    endcase
  end

  assign tick_inc = {1'b0, tick_r} + 10'd1;

  // Advance on ticks, start or reject on commands
  always_comb begin
    phase_nxt    = phase_r;
    tick_nxt     = tick_r;
    bit_nxt      = bit_r;
    shift_nxt    = shift_r;
    presence_nxt = presence_r;
    rx_nxt       = rx_r;
    done         = 1'b0;
    rej          = 1'b0;
    fin          = 1'b0;
    if (step) begin
      if (item.kind == KIND_TICK) begin
        if (phase_r != PH_IDLE) begin
          if (tick_inc < {1'b0, len}) begin
            tick_nxt = tick_inc[8:0];
          end else begin
            tick_nxt = '0;
            case (phase_r)
              PH_RST_LOW: phase_nxt = PH_RST_WT;
              PH_RST_WT: begin
                presence_nxt = item.bus_level;
                phase_nxt    = PH_RST_REC;
              end
              PH_RST_REC: fin = 1'b1;
              PH_WR_LOW:  phase_nxt = PH_WR_HIGH;
              PH_WR_HIGH: begin
                if (bit_r == LAST_BIT) begin
                  fin = 1'b1;
                end else begin
                  bit_nxt   = bit_r + 3'd1;
                  shift_nxt = {1'b0, shift_r[7:1]};
                  phase_nxt = PH_WR_LOW;
                end
              end
              PH_RD_LOW: phase_nxt = PH_RD_WT;
              PH_RD_WT: begin
                shift_nxt = {item.bus_level, shift_r[7:1]};
                phase_nxt = PH_RD_REC;
              end
              PH_RD_REC: begin
                if (bit_r == LAST_BIT) begin
                  rx_nxt = shift_r;
                  fin    = 1'b1;
                end else begin
                  bit_nxt   = bit_r + 3'd1;
                  phase_nxt = PH_RD_LOW;
                end
              end
              default: fin = 1'b1;
            endcase
            if (fin) begin
              phase_nxt = PH_IDLE;
              bit_nxt   = '0;
              done      = 1'b1;
            end
          end
        end
      end else if (phase_r != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        tick_nxt = '0;
        bit_nxt  = '0;
        case (item.kind)
          KIND_RESET: phase_nxt = PH_RST_LOW;
          KIND_WRITE: begin
            shift_nxt = item.tx_byte;
            phase_nxt = PH_WR_LOW;
          end
          default: begin
            shift_nxt = '0;
            phase_nxt = PH_RD_LOW;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      tick_r     <= '0;
      bit_r      <= '0;
      shift_r    <= '0;
      presence_r <= 1'b1;
      rx_r       <= '0;
    end else begin
      phase_r    <= phase_nxt;
      tick_r     <= tick_nxt;
      bit_r      <= bit_nxt;
      shift_r    <= shift_nxt;
      presence_r <= presence_nxt;
      rx_r       <= rx_nxt;
    end
  end

  // Result reflects the state after this beat
  always_comb begin
    result.drive_low      = (phase_nxt == PH_RST_LOW) || (phase_nxt == PH_WR_LOW) ||
                            (phase_nxt == PH_RD_LOW);
    result.busy_res       = (phase_nxt != PH_IDLE);
    result.done_res       = done;
    result.rx_byte        = rx_nxt;
    result.presence_level = presence_nxt;
    result.rejected       = rej;
  end

endmodule
`default_nettype wire

// ===== sv/one_wire_bus_master_unit.sv =====
// Top level of the 1-Wire bus master: input stage, timing engine, result register.
// An accepted input beat is held in the input register, and its result then in the result register.
// Throughput: one beat per cycle while results are taken; a waiting result stalls the input
// only once the input register also holds a beat.
// Reset (rst_n low, synchronous): idle phase, counters and shift byte zero,
// presence level one, received byte zero, both stages empty.
`default_nettype none
module one_wire_bus_master_unit (
  input  wire         clk,
  input  wire         rst_n,
  input  wire         in_tvalid,
  output logic        in_tready,
  input  wire  [15:0] in_tdata,   // [7:0] tx_byte, [8] bus_level, [15:9] zero
  input  wire  [1:0]  in_tuser,   // [1:0] kind
  output logic        out_tvalid,
  input  wire         out_tready,
  output logic [15:0] out_tdata   // [0] drive_low, [1] busy_res, [2] done_res,
                                  // [10:3] rx_byte, [11] presence_level,
                                  // [12] rejected, [15:13] zero
);
  import owb_pkg::*;

  item_t   in_item, item;
  logic    item_valid, step;
  result_t result;
  logic    out_valid_r, out_valid_nxt;
  result_t out_r, out_nxt;

  always_comb begin
    in_item.kind      = kind_t'(in_tuser);
    in_item.tx_byte   = in_tdata[7:0];
    in_item.bus_level = in_tdata[8];
  end

  owb_in_stage u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .take       (step),
    .item_valid (item_valid),
    .item       (item)
  );

  // Process the held beat when the result register has room
  assign step = item_valid && (!out_valid_r || out_tready);

  owb_engine u_eng (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .item   (item),
    .result (result)
  );

  // Hold the result until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (step) begin
      out_valid_nxt = 1'b1;
      out_nxt       = result;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_r <= out_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'b000, out_r};

endmodule
`default_nettype wire

// ===== tb/tb_one_wire_bus_master_unit.sv =====
// Testbench for the 1-Wire bus master: timed reset, write and read operations with checked results.
`timescale 1ns / 1ps
module tb_one_wire_bus_master_unit;
  import owb_pkg::*;

  // Tracks the bus master state per accepted beat and checks every result beat
  class owb_scoreboard;
    phase_t     ph;
    logic [8:0] ticks;
    logic [2:0] bit_idx;
    logic [7:0] shreg;
    logic       presence;
    logic [7:0] rx_last;
    result_t    owb_result_q[$];
    int         errors;

    function new();
      ph       = PH_IDLE;
      ticks    = '0;
      bit_idx  = '0;
      shreg    = '0;
      presence = 1'b1;
      rx_last  = '0;
      errors   = 0;
    endfunction

    function bit busy();
      return ph != PH_IDLE;
    endfunction

    function int pending();
      return owb_result_q.size();
    endfunction

    // Length of the current slot phase in ticks
    function logic [8:0] slot_len();
      case (ph)
        PH_RST_LOW: return RESET_LOW_TICKS;
        PH_RST_WT:  return RST_WAIT_TICKS;
        PH_RST_REC: return RST_REC_TICKS;
        PH_WR_LOW:  return shreg[0] ? WR1_LOW_TICKS : WR0_LOW_TICKS;
        PH_WR_HIGH: return shreg[0] ? WR1_HIGH_TICKS : WR0_HIGH_TICKS;
        PH_RD_LOW:  return RD_LOW_TICKS;
        PH_RD_WT:   return RD_WAIT_TICKS;
        PH_RD_REC:  return RD_REC_TICKS;
        default:    return ONE_TICK;
      endcase
    endfunction

    // Advance the active operation by one microsecond; return 1 when it finishes
    function bit step_time(logic lvl);
      logic [8:0] len;
      bit         fin;
      len = slot_len();
      fin = 1'b0;
      if ({1'b0, ticks} + 10'd1 < {1'b0, len}) begin
        ticks = ticks + 9'd1;
        return 1'b0;
      end
      ticks = '0;
      case (ph)
        PH_RST_LOW: ph = PH_RST_WT;
        PH_RST_WT: begin
          presence = lvl;
          ph = PH_RST_REC;
        end
        PH_RST_REC: fin = 1'b1;
        PH_WR_LOW:  ph = PH_WR_HIGH;
        PH_WR_HIGH: begin
          if (bit_idx == LAST_BIT) begin
            fin = 1'b1;
          end else begin
            bit_idx = bit_idx + 3'd1;
            shreg = shreg >> 1;
            ph = PH_WR_LOW;
          end
        end
        PH_RD_LOW: ph = PH_RD_WT;
        PH_RD_WT: begin
          shreg = {lvl, shreg[7:1]};
          ph = PH_RD_REC;
        end
        PH_RD_REC: begin
          if (bit_idx == LAST_BIT) begin
            rx_last = shreg;
            fin = 1'b1;
          end else begin
            bit_idx = bit_idx + 3'd1;
            ph = PH_RD_LOW;
          end
        end
        default: fin = 1'b1;
      endcase
      if (fin) begin
        ph = PH_IDLE;
        bit_idx = '0;
      end
      return fin;
    endfunction

    // Apply one accepted input beat and queue the result it causes
    function void note_beat(kind_t k, logic [7:0] txb, logic lvl);
      result_t r;
      logic    done, rej;
      done = 1'b0;
      rej  = 1'b0;
      if (k == KIND_TICK) begin
        if (ph != PH_IDLE) done = step_time(lvl);
      end else if (ph != PH_IDLE) begin
        rej = 1'b1;
      end else begin
        ticks = '0;
        bit_idx = '0;
        case (k)
          KIND_RESET: ph = PH_RST_LOW;
          KIND_WRITE: begin
            shreg = txb;
            ph = PH_WR_LOW;
          end
          default: begin
            shreg = '0;
            ph = PH_RD_LOW;
          end
        endcase
      end
      r.drive_low      = (ph == PH_RST_LOW || ph == PH_WR_LOW || ph == PH_RD_LOW);
      r.busy_res       = (ph != PH_IDLE);
      r.done_res       = done;
      r.rx_byte        = rx_last;
      r.presence_level = presence;
      r.rejected       = rej;
      owb_result_q.push_back(r);
    endfunction

    function void cmp(string fname, int unsigned want, int unsigned got);
      if (want != got) begin
        $error("%s: expected %0d, actual %0d", fname, want, got);
        errors++;
      end
    endfunction

    // Compare one result beat against the oldest expectation
    function void check_result(logic [15:0] data);
      result_t want, got;
      if (owb_result_q.size() == 0) begin
        $error("result beat %h with nothing expected", data);
        errors++;
        return;
      end
      want = owb_result_q.pop_front();
      got  = data[12:0];
      cmp("drive_low", want.drive_low, got.drive_low);
      cmp("busy_res", want.busy_res, got.busy_res);
      cmp("done_res", want.done_res, got.done_res);
      cmp("rx_byte", want.rx_byte, got.rx_byte);
      cmp("presence_level", want.presence_level, got.presence_level);
      cmp("rejected", want.rejected, got.rejected);
      cmp("pad", 0, data[15:13]);
    endfunction

    // Flag expectations that never got a result
    function void flush();
      while (owb_result_q.size() != 0) begin
        void'(owb_result_q.pop_front());
        $error("expected result beat never arrived");
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;   // [7:0] tx_byte, [8] bus_level, [15:9] zero
  logic [1:0]  in_tuser;   // [1:0] kind
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;  // [0] drive_low, [1] busy_res, [2] done_res,
                           // [10:3] rx_byte, [11] presence_level, [12] rejected

  owb_scoreboard sb = new();
  bit            calm;
  int            hold_asks;
  int            hold_seen;
  int            hold_left;

  one_wire_bus_master_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  // 4 ns clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Drive result back-pressure: random stalls plus requested long hold-offs
  initial begin
    hold_seen = 0;
    hold_left = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left = hold_left - 1;
    end else if (hold_asks != hold_seen) begin
      hold_seen = hold_asks;
      hold_left = 63;
      out_tready <= 1'b0;
    end else begin
      out_tready <= calm || ($urandom_range(0, 99) >= 12);
    end
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // Offer one beat, with an occasional random gap first unless calm, and wait for acceptance
  task automatic send_beat(kind_t k, logic [7:0] txb, logic lvl);
    if (!calm && $urandom_range(0, 99) < 12) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, lvl, txb};
    in_tuser  <= k;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_beat(k, txb, lvl);
  endtask

  // Line level for a tick: 0 all low, 1 all high, else random
  function automatic logic pick_level(int mode);
    if (mode == 0) return 1'b0;
    if (mode == 1) return 1'b1;
    return 1'($urandom_range(0, 1));
  endfunction

  // Tick until the operation ends, with some commands thrown in while busy
  task automatic finish_op(int mode, int noise_pct);
    while (sb.busy()) begin
      if ($urandom_range(0, 99) < noise_pct)
        send_beat(kind_t'($urandom_range(1, 3)), 8'($urandom), pick_level(mode));
      else
        send_beat(KIND_TICK, 8'($urandom), pick_level(mode));
    end
  endtask

  task automatic run_op(kind_t k, logic [7:0] txb, int mode, int noise_pct);
    send_beat(k, txb, pick_level(mode));
    finish_op(mode, noise_pct);
  endtask

  // Hold the input until every expected result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    @(posedge clk);
  endtask

  // Stimulus and end of run
  initial begin
    int waited;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tuser  <= KIND_TICK;
    calm      = 1'b0;
    hold_asks = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Ticks while idle change nothing
    send_beat(KIND_TICK, 8'h00, 1'b0);
    send_beat(KIND_TICK, 8'hFF, 1'b1);

    // Reset with a device answering, commands rejected while busy,
    // and a long result hold-off while ticks keep coming
    send_beat(KIND_RESET, 8'h00, 1'b0);
    send_beat(KIND_RESET, 8'hFF, 1'b1);
    send_beat(KIND_WRITE, 8'h5A, 1'b0);
    send_beat(KIND_READ, 8'hA5, 1'b1);
    hold_asks = hold_asks + 1;
    finish_op(0, 1);
    send_beat(KIND_TICK, 8'h00, 1'b1);

    // Pause the sender until every result is back
    drain();

    // Write a mix of zero and one slots with no idling on either side
    calm = 1'b1;
    run_op(KIND_WRITE, 8'hA5, 2, 1);
    calm = 1'b0;

    // Read with random line levels
    run_op(KIND_READ, 8'h3C, 2, 1);
    send_beat(KIND_TICK, 8'h00, 1'b0);

    // Wait out the remaining results, then the pipeline latency
    in_tvalid <= 1'b0;
    waited = 0;
    while (sb.pending() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    repeat (8) @(posedge clk);
    sb.flush();
    if (sb.errors == 0)
      $display("PASS one_wire_bus_master_unit");
    else
      $display("FAIL one_wire_bus_master_unit");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("FAIL one_wire_bus_master_unit");
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/owb_pkg.sv
sv/owb_in_stage.sv
sv/owb_engine.sv
sv/one_wire_bus_master_unit.sv
tb/tb_one_wire_bus_master_unit.sv
